// ===== rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, constants and helper functions shared by the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 5;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int RSP_DEPTH   = 3;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 2;

   localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'd10;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 32'hFFFF_FFFF;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic KIND_LINE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_PATTERN_LEN  = 3'd2,
      REG_IGNORE_CASE  = 3'd3,
      REG_INVERT       = 3'd4,
      REG_COUNT_ONLY   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic ignore_case;
   } cell_ctrl_type;

   typedef struct packed {
      logic               record_kind;
      logic [COUNT_W-1:0] line_number;
      logic [COUNT_W-1:0] selected_count;
      logic               last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_push_type;

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                              input logic ic);
      logic [BYTE_W-1:0] r;
      r = c;
      if (ic && (c >= 8'd65) && (c <= 8'd90)) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [63:0] low,
                                                      input logic [63:0] high,
                                                      input logic [LEN_W-1:0] k);
      logic [BYTE_W-1:0] r;
      r = '0;
      if (k[LEN_W-1:3] == 2'd0) begin
         r = low[{k[2:0], 3'b000} +: BYTE_W];
      end else if (k[LEN_W-1:3] == 2'd1) begin
         r = high[{k[2:0], 3'b000} +: BYTE_W];
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_LIMIT) ? v : v + 32'd1;
   endfunction

endpackage

// ===== rtl/lsf_req_if.sv =====
// ----------------------------------------------------------------------------
// lsf_req_if
// Input channel: one text byte or an end-of-text mark per word.
// ----------------------------------------------------------------------------
interface lsf_req_if;
   import lsf_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output command, output text_byte, input ready);
   modport sink (input valid, input command, input text_byte, output ready);
endinterface

// ===== rtl/lsf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lsf_rsp_if
// Result channel: selected line records and end-of-text summaries.
// ----------------------------------------------------------------------------
interface lsf_rsp_if;
   import lsf_pkg::*;

   logic               valid;
   logic               ready;
   logic               record_kind;
   logic [COUNT_W-1:0] line_number;
   logic [COUNT_W-1:0] selected_count;
   logic               last_of_run;

   modport source (output valid, output record_kind, output line_number,
                   output selected_count, output last_of_run, input ready);
   modport sink (input valid, input record_kind, input line_number,
                 input selected_count, input last_of_run, output ready);
endinterface

// ===== rtl/lsf_csr_if.sv =====
// ----------------------------------------------------------------------------
// lsf_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lsf_csr_if;
   import lsf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/line_substring_filter.sv =====
// ----------------------------------------------------------------------------
// line_substring_filter
// Fixed-string line filter: a chain of window cells checks each line for the
// configured pattern; line records and summaries leave through a buffer.
// ----------------------------------------------------------------------------
// result words are registered in the result buffer before they are offered
// throughput: one text word per cycle while the result buffer has room
// an end of text that also closes a selected line gives two results unless
// count-only mode is set; input stalls with fewer than two free places
// reset clears registers, counters, the window and the result buffer
module line_substring_filter (
   input logic        clock,
   input logic        reset,
   lsf_req_if.sink    req_port,
   lsf_rsp_if.source  rsp_port,
   lsf_csr_if.sink    csr_port
);
   import lsf_pkg::*;

   logic [63:0]      pattern_low_ff, pattern_high_ff;
   logic [LEN_W-1:0] pattern_length_ff;
   logic             ignore_case_ff, invert_ff, count_only_ff;

   logic               line_contains_ff, line_contains_in;
   logic               line_open_ff, line_open_in;
   logic [COUNT_W-1:0] current_line_ff, current_line_in;
   logic [COUNT_W-1:0] match_total_ff, match_total_in;

   cell_ctrl_type     cell_ctrl;
   logic [BYTE_W-1:0] cell_byte   [PATTERN_MAX];
   logic [BYTE_W-1:0] wanted      [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_filled, cell_ok, cell_active;

   logic               accept, is_end, is_nl, is_data, finish, hit, selected, record;
   logic               len_ok, window_match, room;
   logic [COUNT_W-1:0] line_fin, total_fin, line_after, total_after;
   rsp_word_type       record_word, summary_word;
   rsp_push_type       push;

   // configuration registers
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         ignore_case_ff    <= 1'b0;
         invert_ff         <= 1'b0;
         count_only_ff     <= 1'b0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_PATTERN_LOW:  pattern_low_ff    <= csr_port.data;
            REG_PATTERN_HIGH: pattern_high_ff   <= csr_port.data;
            REG_PATTERN_LEN:  pattern_length_ff <= csr_port.data[LEN_W-1:0];
            REG_IGNORE_CASE:  ignore_case_ff    <= csr_port.data[0];
            REG_INVERT:       invert_ff         <= csr_port.data[0];
            REG_COUNT_ONLY:   count_only_ff     <= csr_port.data[0];
            default: ;
         endcase
      end
   end

   // word decode
   assign accept  = req_port.valid && req_port.ready;
   assign is_end  = req_port.command == CMD_END;
   assign is_nl   = !is_end && (req_port.text_byte == NEWLINE_BYTE);
   assign is_data = !is_end && !is_nl;

   assign cell_ctrl.shift       = accept && is_data;
   assign cell_ctrl.clear       = accept && !is_data;
   assign cell_ctrl.ignore_case = ignore_case_ff;

   // cell chain, cell i compares the byte i places back
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         cell_active[i] = 32'(i) < 32'(pattern_length_ff);
         wanted[i] = pattern_byte(pattern_low_ff, pattern_high_ff,
                                  LEN_W'(pattern_length_ff - LEN_W'(1) - LEN_W'(i)));
      end
   end

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      if (g == 0) begin : g_head
         lsf_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .near_byte   (req_port.text_byte),
            .near_filled (1'b1),
            .wanted_byte (wanted[g]),
            .active      (cell_active[g]),
            .byte_out    (cell_byte[g]),
            .filled_out  (cell_filled[g]),
            .ok          (cell_ok[g])
         );
      end else begin : g_body
         lsf_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .near_byte   (cell_byte[g-1]),
            .near_filled (cell_filled[g-1]),
            .wanted_byte (wanted[g]),
            .active      (cell_active[g]),
            .byte_out    (cell_byte[g]),
            .filled_out  (cell_filled[g]),
            .ok          (cell_ok[g])
         );
      end
   end

   assign len_ok = (pattern_length_ff != '0) &&
                   (32'(pattern_length_ff) <= 32'(PATTERN_MAX));
   assign window_match = len_ok && (&cell_ok);

   // line bookkeeping
   assign finish      = accept && (is_nl || (is_end && line_open_ff));
   assign hit         = (pattern_length_ff == '0) || line_contains_ff;
   assign selected    = hit ^ invert_ff;
   assign record      = finish && selected && !count_only_ff;
   assign line_fin    = sat_inc(current_line_ff);
   assign total_fin   = selected ? sat_inc(match_total_ff) : match_total_ff;
   assign line_after  = finish ? line_fin : current_line_ff;
   assign total_after = finish ? total_fin : match_total_ff;

   always_comb begin
      line_contains_in = line_contains_ff;
      line_open_in     = line_open_ff;
      current_line_in  = current_line_ff;
      match_total_in   = match_total_ff;
      if (accept) begin
         priority if (is_end) begin
            line_contains_in = 1'b0;
            line_open_in     = 1'b0;
            current_line_in  = '0;
            match_total_in   = '0;
         end else if (is_nl) begin
            line_contains_in = 1'b0;
            line_open_in     = 1'b0;
            current_line_in  = line_fin;
            match_total_in   = total_fin;
         end else begin
            line_open_in     = 1'b1;
            line_contains_in = line_contains_ff || window_match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_contains_ff <= 1'b0;
         line_open_ff     <= 1'b0;
         current_line_ff  <= '0;
         match_total_ff   <= '0;
      end else begin
         line_contains_ff <= line_contains_in;
         line_open_ff     <= line_open_in;
         current_line_ff  <= current_line_in;
         match_total_ff   <= match_total_in;
      end
   end

   // result words
   always_comb begin
      record_word.record_kind     = KIND_LINE;
      record_word.line_number     = line_after;
      record_word.selected_count  = '0;
      record_word.last_of_run     = !is_end;
      summary_word.record_kind    = KIND_SUMMARY;
      summary_word.line_number    = line_after;
      summary_word.selected_count = total_after;
      summary_word.last_of_run    = 1'b1;

      push.count  = 2'd0;
      push.first  = record_word;
      push.second = summary_word;
      priority if (record && is_end) begin
         push.count = 2'd2;
      end else if (record) begin
         push.count = 2'd1;
      end else if (accept && is_end) begin
         push.count = 2'd1;
         push.first = summary_word;
      end else begin
         push.count = 2'd0;
      end
   end

   lsf_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_port)
   );

   assign req_port.ready = room;

   a_total_within_lines: assert property (@(posedge clock) disable iff (reset)
      match_total_ff <= current_line_ff)
      else $error("selected count above line count");

   a_open_tracks_chain: assert property (@(posedge clock) disable iff (reset)
      line_open_ff == cell_filled[0])
      else $error("line open flag disagrees with head cell");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> current_line_ff == '0 && match_total_ff == '0 &&
                           !line_open_ff && !line_contains_ff)
      else $error("end of text did not clear line state");

endmodule

// ===== rtl/lsf_cell.sv =====
// ----------------------------------------------------------------------------
// lsf_cell
// One window cell: holds one recent byte of the line and compares the byte
// arriving from its neighbor with its pattern byte.
// ----------------------------------------------------------------------------
module lsf_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lsf_pkg::cell_ctrl_type      ctrl,
   input  logic [lsf_pkg::BYTE_W-1:0]  near_byte,
   input  logic                        near_filled,
   input  logic [lsf_pkg::BYTE_W-1:0]  wanted_byte,
   input  logic                        active,
   output logic [lsf_pkg::BYTE_W-1:0]  byte_out,
   output logic                        filled_out,
   output logic                        ok
);
   import lsf_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              filled_ff, filled_in;

   always_comb begin
      byte_in   = byte_ff;
      filled_in = filled_ff;
      if (ctrl.clear) begin
         filled_in = 1'b0;
      end else if (ctrl.shift) begin
         byte_in   = near_byte;
         filled_in = near_filled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_out   = byte_ff;
   assign filled_out = filled_ff;
   assign ok = !active || (near_filled &&
               (fold(near_byte, ctrl.ignore_case) == fold(wanted_byte, ctrl.ignore_case)));

endmodule

// ===== rtl/lsf_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// lsf_rsp_fifo
// Three-word result buffer taking up to two words per cycle.
// ----------------------------------------------------------------------------
module lsf_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  lsf_pkg::rsp_push_type push,
   output logic                  room,
   lsf_rsp_if.source             rsp
);
   import lsf_pkg::*;

   function automatic logic [RSP_PTR_W-1:0] next_ptr(input logic [RSP_PTR_W-1:0] p);
      return (p == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   rsp_word_type       mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rd_ff, rd_in, wr_ff, wr_in, wr_one, wr_two;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   rsp_word_type         head;

   assign pop    = rsp.valid && rsp.ready;
   assign wr_one = next_ptr(wr_ff);
   assign wr_two = next_ptr(wr_one);
   assign head   = mem[rd_ff];

   always_comb begin
      rd_in    = pop ? next_ptr(rd_ff) : rd_ff;
      count_in = RSP_CNT_W'(3'(count_ff) + 3'(push.count) - 3'(pop));
      unique case (push.count)
         2'd1:    wr_in = wr_one;
         2'd2:    wr_in = wr_two;
         default: wr_in = wr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_one] <= push.second;
      end
   end

   assign room               = count_ff <= RSP_CNT_W'(1);
   assign rsp.valid          = count_ff != '0;
   assign rsp.record_kind    = head.record_kind;
   assign rsp.line_number    = head.line_number;
   assign rsp.selected_count = head.selected_count;
   assign rsp.last_of_run    = head.last_of_run;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result buffer count beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= RSP_CNT_W'(RSP_DEPTH - 2))
      else $error("result pushed without two free places");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result buffer count did not drop on pop");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Line substring filter testbench. Text words and end-of-text marks go in
// with random gaps while the result side stalls at random. A behavioral
// model of the filter predicts every line record and summary, and each
// result word is checked field by field against the oldest prediction.
// Directed tests cover the default setup, case folding, inverted and
// count-only selection, overlong and newline patterns and a mid-line
// pattern change. Random phases then run well-formed lines with embedded
// patterns mixed with noise.
// ----------------------------------------------------------------------------
module tb_top;
   import lsf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 42;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsf_req_if req_bus ();
   lsf_rsp_if rsp_bus ();
   lsf_csr_if csr_bus ();

   line_substring_filter u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // filter model state
   logic [63:0]        pat_low    = '0;
   logic [63:0]        pat_high   = '0;
   logic [LEN_W-1:0]   pat_len    = '0;
   logic               cfg_fold   = 1'b0;
   logic               cfg_invert = 1'b0;
   logic               cfg_quiet  = 1'b0;
   logic [BYTE_W-1:0]  recent [PATTERN_MAX];
   int unsigned        fill       = 0;
   logic               line_hit   = 1'b0;
   logic               line_busy  = 1'b0;
   logic [COUNT_W-1:0] line_total = '0;
   logic [COUNT_W-1:0] sel_total  = '0;

   rsp_word_type pending_words [$];
   int           errors      = 0;
   int           quiet_cycles = 0;
   logic         steady      = 1'b0;

   initial begin
      foreach (recent[i]) recent[i] = '0;
   end

   function automatic logic [BYTE_W-1:0] fold_letter(input logic [BYTE_W-1:0] c);
      if (cfg_fold && c >= 8'd65 && c <= 8'd90) return c + 8'd32;
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] pat_at(input int k);
      if (k < 8) return pat_low[8*k +: 8];
      if (k < 16) return pat_high[8*(k-8) +: 8];
      return '0;
   endfunction

   function automatic logic window_hit();
      int unsigned n;
      n = pat_len;
      if (n == 0 || n > PATTERN_MAX || fill < n) return 1'b0;
      for (int k = 0; k < n; k++) begin
         if (fold_letter(recent[n-1-k]) != fold_letter(pat_at(k))) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void wipe_line();
      foreach (recent[i]) recent[i] = '0;
      fill      = 0;
      line_hit  = 1'b0;
      line_busy = 1'b0;
   endfunction

   function automatic void close_line();
      logic         chosen;
      rsp_word_type w;
      chosen = ((pat_len == 0) || line_hit) != cfg_invert;
      if (line_total != COUNT_LIMIT) line_total = line_total + 1;
      if (chosen) begin
         if (sel_total != COUNT_LIMIT) sel_total = sel_total + 1;
         if (!cfg_quiet) begin
            w.record_kind    = KIND_LINE;
            w.line_number    = line_total;
            w.selected_count = '0;
            w.last_of_run    = 1'b0;
            pending_words.push_back(w);
         end
      end
      wipe_line();
   endfunction

   function automatic void filter_predict(input logic cmd, input logic [BYTE_W-1:0] b);
      int           first_new;
      rsp_word_type w;
      first_new = pending_words.size();
      if (cmd == CMD_END) begin
         if (line_busy) close_line();
         w.record_kind    = KIND_SUMMARY;
         w.line_number    = line_total;
         w.selected_count = sel_total;
         w.last_of_run    = 1'b0;
         pending_words.push_back(w);
         wipe_line();
         line_total = '0;
         sel_total  = '0;
      end else if (b == NEWLINE_BYTE) begin
         close_line();
      end else begin
         for (int i = PATTERN_MAX - 1; i > 0; i--) recent[i] = recent[i-1];
         recent[0] = b;
         if (fill < PATTERN_MAX) fill++;
         line_busy = 1'b1;
         if (window_hit()) line_hit = 1'b1;
      end
      if (pending_words.size() > first_new) pending_words[$].last_of_run = 1'b1;
   endfunction

   task automatic note_error(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      $display("error at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            note_error("unexpected word", rsp_bus.line_number, '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_bus.record_kind !== want.record_kind)
               note_error("record_kind", 32'(rsp_bus.record_kind),
                          32'(want.record_kind));
            if (rsp_bus.line_number !== want.line_number)
               note_error("line_number", rsp_bus.line_number, want.line_number);
            if (rsp_bus.selected_count !== want.selected_count)
               note_error("selected_count", rsp_bus.selected_count, want.selected_count);
            if (rsp_bus.last_of_run !== want.last_of_run)
               note_error("last_of_run", 32'(rsp_bus.last_of_run),
                          32'(want.last_of_run));
         end
      end
   end

   // result side stalls
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic cmd, input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 13) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.text_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      filter_predict(cmd, b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(CMD_BYTE, s[i]);
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_PATTERN_LOW:  pat_low    = value;
         REG_PATTERN_HIGH: pat_high   = value;
         REG_PATTERN_LEN:  pat_len    = value[LEN_W-1:0];
         REG_IGNORE_CASE:  cfg_fold   = value[0];
         REG_INVERT:       cfg_invert = value[0];
         REG_COUNT_ONLY:   cfg_quiet  = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_filter(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [LEN_W-1:0] len, input logic ic,
                             input logic inv, input logic quiet);
      csr_write(REG_PATTERN_LOW, lo);
      csr_write(REG_PATTERN_HIGH, hi);
      csr_write(REG_PATTERN_LEN, {59'd0, len});
      csr_write(REG_IGNORE_CASE, {63'd0, ic});
      csr_write(REG_INVERT, {63'd0, inv});
      csr_write(REG_COUNT_ONLY, {63'd0, quiet});
   endtask

   function automatic logic [BYTE_W-1:0] random_letter();
      return (8'h61 + 8'($urandom_range(1))) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
   endfunction

   function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] low;
      low = c | 8'h20;
      if (cfg_fold && low >= 8'h61 && low <= 8'h7A && $urandom_range(1)) return c ^ 8'h20;
      return c;
   endfunction

   // empty pattern after reset: every line is selected, empty text too
   task automatic test_default_config();
      send_word(CMD_END, 8'h00);
      send_text("\n");
      send_text("ab\n");
      send_text("c");
      send_word(CMD_END, 8'hFF);
   endtask

   task automatic test_case_fold();
      settle();
      set_filter(64'h0043_6241, 64'h0, 5'd3, 1'b1, 1'b0, 1'b0);
      send_text("aBcx\n");
      send_text("abd");
      send_word(CMD_END, 8'h00);
   endtask

   task automatic test_invert_count_only();
      settle();
      set_filter(64'h0, 64'h0, 5'd1, 1'b0, 1'b1, 1'b1);
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, 8'hFF);
      send_text("\n");
      send_word(CMD_BYTE, 8'hFF);
      send_text("\n");
      send_word(CMD_END, 8'h00);
   endtask

   task automatic test_overlong_pattern();
      settle();
      set_filter(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31,
                 1'b0, 1'b0, 1'b0);
      send_text("aa\n");
      send_word(CMD_END, 8'h00);
   endtask

   task automatic test_newline_pattern();
      settle();
      set_filter(64'h0A, 64'h0, 5'd1, 1'b0, 1'b0, 1'b0);
      send_text("x\n");
      send_word(CMD_END, 8'h00);
   endtask

   task automatic test_midline_change();
      settle();
      set_filter(64'h7A7A, 64'h0, 5'd2, 1'b0, 1'b0, 1'b0);
      send_text("ab");
      settle();
      csr_write(REG_PATTERN_LOW, 64'h6362);
      send_text("c\n");
      send_word(CMD_END, 8'h00);
   endtask

   task automatic test_random_text();
      int                items;
      int                len;
      int                pick;
      logic [63:0]       lo;
      logic [63:0]       hi;
      logic [LEN_W-1:0]  plen;
      logic [BYTE_W-1:0] c;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         steady = (phase == 3);
         lo = '0;
         hi = '0;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            pick = $urandom_range(99);
            if (pick < 60) c = random_letter();
            else if (pick < 80) c = 8'($urandom_range(255));
            else c = 8'($urandom_range(126, 32));
            if (k < 8) lo[8*k +: 8] = c;
            else hi[8*(k-8) +: 8] = c;
         end
         case ($urandom_range(9))
            0:       plen = 5'd0;
            1:       plen = 5'd16;
            2:       plen = LEN_W'($urandom_range(31, 17));
            3, 4:    plen = LEN_W'($urandom_range(16, 1));
            default: plen = LEN_W'($urandom_range(4, 1));
         endcase
         set_filter(lo, hi, plen, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom_range(3) == 0);
         items = 0;
         while (items < PHASE_WORDS) begin
            if ($urandom_range(99) < 3) settle();
            len = ($urandom_range(99) < 5) ? $urandom_range(30, 20) : $urandom_range(12);
            for (int j = 0; j < len; j++) begin
               if (plen >= 1 && plen <= PATTERN_MAX && $urandom_range(99) < 15) begin
                  for (int k = 0; k < plen; k++) send_word(CMD_BYTE, vary_case(pat_at(k)));
                  items += plen;
               end else begin
                  pick = $urandom_range(99);
                  if (pick < 45) c = pat_at($urandom_range(PATTERN_MAX - 1));
                  else if (pick < 75) c = random_letter();
                  else c = 8'($urandom_range(255));
                  send_word(CMD_BYTE, c);
                  items++;
               end
            end
            if ($urandom_range(9) == 0) send_word(CMD_END, 8'($urandom_range(255)));
            else send_word(CMD_BYTE, NEWLINE_BYTE);
            items++;
         end
      end
      send_word(CMD_END, 8'($urandom_range(255)));
      steady = 1'b0;
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_BYTE;
      req_bus.text_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_PATTERN_LOW;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_case_fold();
      test_invert_count_only();
      test_overlong_pattern();
      test_newline_pattern();
      test_midline_change();
      test_random_text();

      settle();
      repeat (5) @(posedge clock);
      if (pending_words.size() != 0)
         note_error("words outstanding", pending_words.size(), 0);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lsf_pkg.sv
rtl/lsf_req_if.sv
rtl/lsf_rsp_if.sv
rtl/lsf_csr_if.sv
rtl/lsf_cell.sv
rtl/lsf_rsp_fifo.sv
rtl/line_substring_filter.sv
tb/sv/tb_top.sv
